FILE: hw/rtl/c2s_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2s_pkg: shared types and constants for the cartesian to spherical core
// Datapath widths, the CORDIC arctangent table, angle codes and the records
// that travel down the pipeline.
// ----------------------------------------------------------------------------
package c2s_pkg;

	// angle and datapath widths
	localparam int ANG_W      = 16;
	localparam int ACC_FRAC   = 32;          // accumulator: 2^32 per full turn
	localparam int AW         = 34;          // signed angle accumulator
	localparam int CW         = 43;          // signed CORDIC vector component
	localparam int GUARD_BITS = 8;

	// square root units: 64-bit radicand, 32-bit root, one bit per stage
	localparam int SQRT_IN_W  = 64;
	localparam int SQRT_OUT_W = SQRT_IN_W / 2;
	localparam int SQRT_LAT   = SQRT_OUT_W + 1;

	// atan(2^-i) at 2^32 per full turn
	localparam int ATAN_LEN = 24;
	localparam logic [31:0] ATAN_TABLE [ATAN_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// accumulator constants
	localparam logic signed [AW-1:0] ACC_QUARTER = AW'(32'h4000_0000);
	localparam logic [AW-1:0]        ANG_RND     = AW'(32'h0000_8000);

	// output angle codes
	localparam logic [ANG_W-1:0] ANG_ZERO         = 16'h0000;
	localparam logic [ANG_W-1:0] ANG_HALF_PI      = 16'h4000;
	localparam logic [ANG_W-1:0] ANG_PI           = 16'h8000;
	localparam logic [ANG_W-1:0] ANG_NEG_HALF_PI  = 16'hC000;
	localparam logic [ANG_W-1:0] RADIUS_MAX       = 16'hFFFF;

	// per-point flags and radius carried alongside the CORDIC stages
	typedef struct packed {
		logic             undef;
		logic             x_zero;
		logic             y_zero;
		logic             z_zero;
		logic             x_neg;
		logic             y_neg;
		logic             z_neg;
		logic [ANG_W-1:0] radius;
	} side_t;

	// one result transaction
	typedef struct packed {
		logic [ANG_W-1:0]        radius;
		logic [ANG_W-1:0]        polar_angle;
		logic signed [ANG_W-1:0] azimuth;
		logic                    undefined;
	} sph_t;

endpackage
`default_nettype wire

FILE: hw/rtl/c2s_point_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2s_point_if: input channel carrying one cartesian point
// Valid/ready handshake with signed x, y and z coordinates.
// ----------------------------------------------------------------------------
interface c2s_point_if #(parameter int COORD_WIDTH = 16);

	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] x_coord;
	logic signed [COORD_WIDTH-1:0] y_coord;
	logic signed [COORD_WIDTH-1:0] z_coord;

	modport source(output valid, output x_coord, output y_coord, output z_coord,
		input ready);
	modport sink(input valid, input x_coord, input y_coord, input z_coord,
		output ready);

endinterface
`default_nettype wire

FILE: hw/rtl/c2s_sphere_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2s_sphere_if: output channel carrying one spherical result
// Valid/ready handshake with radius, polar angle, azimuth and undefined flag.
// ----------------------------------------------------------------------------
interface c2s_sphere_if;
	import c2s_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [ANG_W-1:0]        radius;
	logic [ANG_W-1:0]        polar_angle;
	logic signed [ANG_W-1:0] azimuth;
	logic                    undefined;

	modport source(output valid, output radius, output polar_angle, output azimuth,
		output undefined, input ready);
	modport sink(input valid, input radius, input polar_angle, input azimuth,
		input undefined, output ready);

endinterface
`default_nettype wire

FILE: hw/rtl/cartesian_to_spherical_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cartesian_to_spherical_core: cartesian point to radius, theta and phi
// Squares and exact square roots give the rounded radius and rho; two
// CORDIC vectoring pipelines give the polar angle and the azimuth.
//
//   channel   role    fields
//   point     sink    x_coord, y_coord, z_coord (COORD_WIDTH, signed)
//   sphere    source  radius, polar_angle, azimuth, undefined
//
// One transaction per clock sustained while the output buffer is not full. A point
// passes four front stages, the 33-stage square roots, the CORDIC pipelines
// and the output register.
// Reset clears all valid bits and the delay lines; other payload registers are not reset.
// The pipeline halts only while the two-entry output buffer is full, so
// point.ready is a register output with no path from sphere.ready.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_core #(
	parameter int COORD_WIDTH   = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	c2s_point_if.sink    point,
	c2s_sphere_if.source sphere
);
	import c2s_pkg::*;

	localparam int W        = COORD_WIDTH;
	localparam int W2       = 2 * COORD_WIDTH;
	localparam int SCALE_SH = ACC_FRAC + GUARD_BITS - COORD_WIDTH;
	localparam int RHO_SH   = SQRT_IN_W - W2;
	localparam int SQ_DLY_W = 1 + 3 * COORD_WIDTH;
	localparam int SIDE_W   = 1 + $bits(side_t);
	localparam int OUT_SH   = ACC_FRAC - ANG_W;

	logic en;

	// front stages
	logic                v_s1, v_s2, v_s3, v_s4;
	logic signed [W-1:0] x_s1, y_s1, z_s1;
	logic signed [W-1:0] x_s2, y_s2, z_s2;
	logic signed [W-1:0] x_s3, y_s3, z_s3;
	logic signed [W-1:0] x_s4, y_s4, z_s4;
	logic [W-1:0]        ax_s2, ay_s2, az_s2;
	logic [W2-1:0]       sqx_s3, sqy_s3, sqz_s3;
	logic [W2-1:0]       rho2_s4, sum_s4;

	// square roots
	logic [SQRT_IN_W-1:0]  rad_rho, rad_r;
	logic [SQRT_OUT_W:0]   rho_root, r_root;
	logic [SQ_DLY_W-1:0]   sq_q;
	logic                  sq_v;
	logic signed [W-1:0]   sq_x, sq_y, sq_z;

	// CORDIC setup
	logic signed [CW-1:0] za, xa, yb, rb;
	logic signed [CW-1:0] t_a, t_b, p_a, p_b;
	logic signed [AW-1:0] t_acc, p_acc;
	side_t                side_c;
	logic signed [AW-1:0] acc_t, acc_p;

	// final formatting
	logic [SIDE_W-1:0]          fin_q;
	logic                       fin_v;
	side_t                      fin_side;
	logic signed [AW-1:0]       t_rnd, p_rnd;
	logic signed [AW-OUT_SH-1:0] t_int;
	logic [ANG_W-1:0]           theta_c;
	sph_t                       fin_data;

	// output register and skid entry
	logic o_v_q, sk_v_q;
	sph_t o_data_q, sk_data_q;
	logic take, push;

	assign en          = !sk_v_q;
	assign point.ready = en;

	// valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= point.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// capture, magnitudes, squares, sums
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= point.x_coord;
			y_s1 <= point.y_coord;
			z_s1 <= point.z_coord;

			ax_s2 <= x_s1[W-1] ? $unsigned(-x_s1) : $unsigned(x_s1);
			ay_s2 <= y_s1[W-1] ? $unsigned(-y_s1) : $unsigned(y_s1);
			az_s2 <= z_s1[W-1] ? $unsigned(-z_s1) : $unsigned(z_s1);
			x_s2  <= x_s1;
			y_s2  <= y_s1;
			z_s2  <= z_s1;

			sqx_s3 <= W2'(ax_s2) * W2'(ax_s2);
			sqy_s3 <= W2'(ay_s2) * W2'(ay_s2);
			sqz_s3 <= W2'(az_s2) * W2'(az_s2);
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			z_s3   <= z_s2;

			rho2_s4 <= sqx_s3 + sqy_s3;
			sum_s4  <= sqx_s3 + sqy_s3 + sqz_s3;
			x_s4    <= x_s3;
			y_s4    <= y_s3;
			z_s4    <= z_s3;
		end
	end

	// rho at 2^(32 - COORD_WIDTH) scale, radius rounded to nearest
	assign rad_rho = SQRT_IN_W'(rho2_s4) << RHO_SH;
	assign rad_r   = SQRT_IN_W'(sum_s4);

	c2s_isqrt #(.IN_W(SQRT_IN_W), .ROUND_UP(1'b0)) u_rho_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad_rho),
		.root (rho_root)
	);

	c2s_isqrt #(.IN_W(SQRT_IN_W), .ROUND_UP(1'b1)) u_rad_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad_r),
		.root (r_root)
	);

	c2s_delay #(.WIDTH(SQ_DLY_W), .DEPTH(SQRT_LAT)) u_sq_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      ({v_s4, x_s4, y_s4, z_s4}),
		.q      (sq_q)
	);

	assign {sq_v, sq_x, sq_y, sq_z} = sq_q;

	// scaled vectors and quadrant pre-rotation
	always_comb begin
		za = CW'(sq_z) <<< SCALE_SH;
		xa = CW'(sq_x) <<< SCALE_SH;
		yb = CW'(sq_y) <<< SCALE_SH;
		rb = $signed(CW'(rho_root[SQRT_OUT_W-1:0]) << GUARD_BITS);

		if (sq_z[W-1]) begin
			t_a   = rb;
			t_b   = -za;
			t_acc = ACC_QUARTER;
		end else begin
			t_a   = za;
			t_b   = rb;
			t_acc = '0;
		end

		if (sq_x[W-1]) begin
			if (!sq_y[W-1]) begin
				p_a   = yb;
				p_b   = -xa;
				p_acc = ACC_QUARTER;
			end else begin
				p_a   = -yb;
				p_b   = xa;
				p_acc = -ACC_QUARTER;
			end
		end else begin
			p_a   = xa;
			p_b   = yb;
			p_acc = '0;
		end

		side_c.x_zero = (sq_x == '0);
		side_c.y_zero = (sq_y == '0);
		side_c.z_zero = (sq_z == '0);
		side_c.undef  = side_c.x_zero && side_c.y_zero;
		side_c.x_neg  = sq_x[W-1];
		side_c.y_neg  = sq_y[W-1];
		side_c.z_neg  = sq_z[W-1];
		side_c.radius = (r_root > (SQRT_OUT_W+1)'(RADIUS_MAX)) ? RADIUS_MAX :
			r_root[ANG_W-1:0];
	end

	c2s_cordic #(.STAGES(CORDIC_STAGES)) u_theta (
		.clk     (clk),
		.en      (en),
		.a_in    (t_a),
		.b_in    (t_b),
		.acc_in  (t_acc),
		.acc_out (acc_t)
	);

	c2s_cordic #(.STAGES(CORDIC_STAGES)) u_phi (
		.clk     (clk),
		.en      (en),
		.a_in    (p_a),
		.b_in    (p_b),
		.acc_in  (p_acc),
		.acc_out (acc_p)
	);

	c2s_delay #(.WIDTH(SIDE_W), .DEPTH(CORDIC_STAGES + 1)) u_side_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      ({sq_v, side_c}),
		.q      (fin_q)
	);

	assign {fin_v, fin_side} = fin_q;

	// round the accumulators, clamp theta, apply the exact cases
	always_comb begin
		t_rnd = acc_t + $signed(ANG_RND);
		p_rnd = acc_p + $signed(ANG_RND);
		t_int = t_rnd[AW-1:OUT_SH];

		if (t_int[AW-OUT_SH-1]) begin
			theta_c = ANG_ZERO;
		end else if (t_int > $signed((AW-OUT_SH)'(ANG_PI))) begin
			theta_c = ANG_PI;
		end else begin
			theta_c = t_int[ANG_W-1:0];
		end

		fin_data.radius    = fin_side.radius;
		fin_data.undefined = fin_side.undef;

		if (fin_side.undef) begin
			fin_data.polar_angle = fin_side.z_neg ? ANG_PI : ANG_ZERO;
		end else if (fin_side.z_zero) begin
			fin_data.polar_angle = ANG_HALF_PI;
		end else begin
			fin_data.polar_angle = theta_c;
		end

		if (fin_side.undef) begin
			fin_data.azimuth = ANG_ZERO;
		end else if (fin_side.x_zero) begin
			fin_data.azimuth = fin_side.y_neg ? ANG_NEG_HALF_PI : ANG_HALF_PI;
		end else if (fin_side.y_zero) begin
			fin_data.azimuth = fin_side.x_neg ? ANG_PI : ANG_ZERO;
		end else begin
			fin_data.azimuth = p_rnd[ACC_FRAC-1:OUT_SH];
		end
	end

	// output register with one skid entry
	assign take = o_v_q && sphere.ready;
	assign push = en && fin_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q  <= 1'b0;
			sk_v_q <= 1'b0;
		end else if (sk_v_q) begin
			if (take) begin
				sk_v_q <= 1'b0;
			end
		end else if (push) begin
			o_v_q <= 1'b1;
			if (o_v_q && !take) begin
				sk_v_q <= 1'b1;
			end
		end else if (take) begin
			o_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_v_q) begin
			if (take) begin
				o_data_q <= sk_data_q;
			end
		end else if (push) begin
			if (!o_v_q || take) begin
				o_data_q <= fin_data;
			end else begin
				sk_data_q <= fin_data;
			end
		end
	end

	assign sphere.valid       = o_v_q;
	assign sphere.radius      = o_data_q.radius;
	assign sphere.polar_angle = o_data_q.polar_angle;
	assign sphere.azimuth     = o_data_q.azimuth;
	assign sphere.undefined   = o_data_q.undefined;

	// skid entry is only occupied behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> o_v_q)
		else $error("skid entry full while output register empty");

	// skid entry fills only when the output was held back
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_v_q) |-> $past(o_v_q && !sphere.ready))
		else $error("skid entry filled without a stalled output");

	// theta stays within zero to pi
	a_theta_range: assert property (@(posedge clk) disable iff (!arst_n)
		o_v_q |-> (o_data_q.polar_angle <= ANG_PI))
		else $error("polar angle beyond pi");

	// an undefined point carries a zero azimuth
	a_undef_azimuth: assert property (@(posedge clk) disable iff (!arst_n)
		(o_v_q && o_data_q.undefined) |-> (o_data_q.azimuth == ANG_ZERO))
		else $error("azimuth nonzero on undefined point");

endmodule
`default_nettype wire

FILE: hw/rtl/c2s_delay.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2s_delay: enabled shift line
// Carries valid bits and side data alongside the arithmetic pipelines.
// ----------------------------------------------------------------------------
module c2s_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] line_s [DEPTH];

	// shift on enable, cleared by reset since valid bits ride here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				line_s[i] <= '0;
			end
		end else if (en) begin
			line_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				line_s[i] <= line_s[i-1];
			end
		end
	end

	assign q = line_s[DEPTH-1];

endmodule
`default_nettype wire

FILE: hw/rtl/c2s_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2s_isqrt: pipelined integer square root
// Restoring method, one root bit per stage, then an optional round to
// nearest on the final remainder, registered in a last stage.
// ----------------------------------------------------------------------------
module c2s_isqrt #(
	parameter int IN_W     = 64,
	parameter bit ROUND_UP = 1'b0
) (
	input  logic              clk,
	input  logic              en,
	input  logic [IN_W-1:0]   rad,
	output logic [IN_W/2:0]   root
);

	localparam int OUT_W = IN_W / 2;

	logic [IN_W-1:0]  rem_s [OUT_W];
	logic [OUT_W-1:0] rt_s  [OUT_W];
	logic [IN_W-1:0]  trial [OUT_W];
	logic [OUT_W-1:0] ge;

	// trial subtrahend per stage: (2*root + 2^b) * 2^b
	always_comb begin
		trial[0] = IN_W'(1) << (2 * (OUT_W - 1));
		ge[0]    = (rad >= trial[0]);
		for (int k = 1; k < OUT_W; k++) begin
			trial[k] = (IN_W'(rt_s[k-1]) << (OUT_W - k)) |
				(IN_W'(1) << (2 * (OUT_W - 1 - k)));
			ge[k]    = (rem_s[k-1] >= trial[k]);
		end
	end

	// one result bit per stage
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= ge[0] ? (rad - trial[0]) : rad;
			rt_s[0]  <= OUT_W'(ge[0]) << (OUT_W - 1);
			for (int k = 1; k < OUT_W; k++) begin
				rem_s[k] <= ge[k] ? (rem_s[k-1] - trial[k]) : rem_s[k-1];
				rt_s[k]  <= rt_s[k-1] | (OUT_W'(ge[k]) << (OUT_W - 1 - k));
			end
			// round half up when the remainder exceeds the root
			root <= (OUT_W+1)'(rt_s[OUT_W-1]) + (OUT_W+1)'(ROUND_UP &&
				(rem_s[OUT_W-1] > IN_W'(rt_s[OUT_W-1])));
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/c2s_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2s_cordic: pipelined CORDIC vectoring unit
// Registers the pre-rotated vector, then drives b to zero over STAGES stages
// and accumulates the angle.
// ----------------------------------------------------------------------------
module c2s_cordic #(
	parameter int STAGES = 16
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [c2s_pkg::CW-1:0]  a_in,
	input  logic signed [c2s_pkg::CW-1:0]  b_in,
	input  logic signed [c2s_pkg::AW-1:0]  acc_in,
	output logic signed [c2s_pkg::AW-1:0]  acc_out
);
	import c2s_pkg::*;

	logic signed [CW-1:0] a_s   [STAGES];
	logic signed [CW-1:0] b_s   [STAGES];
	logic signed [AW-1:0] acc_s [STAGES+1];

	always_ff @(posedge clk) begin
		if (en) begin
			// input register
			a_s[0]   <= a_in;
			b_s[0]   <= b_in;
			acc_s[0] <= acc_in;
			// micro-rotations toward the positive a axis
			for (int i = 0; i < STAGES - 1; i++) begin
				if (b_s[i][CW-1]) begin
					a_s[i+1] <= a_s[i] - (b_s[i] >>> i);
					b_s[i+1] <= b_s[i] + (a_s[i] >>> i);
				end else begin
					a_s[i+1] <= a_s[i] + (b_s[i] >>> i);
					b_s[i+1] <= b_s[i] - (a_s[i] >>> i);
				end
			end
			// angle accumulation
			for (int i = 0; i < STAGES; i++) begin
				if (b_s[i][CW-1]) begin
					acc_s[i+1] <= acc_s[i] - $signed(AW'(ATAN_TABLE[i]));
				end else begin
					acc_s[i+1] <= acc_s[i] + $signed(AW'(ATAN_TABLE[i]));
				end
			end
		end
	end

	assign acc_out = acc_s[STAGES];

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for cartesian_to_spherical_core
// Drives points through the valid/ready point channel and predicts the radius,
// polar angle, azimuth and undefined flag of each one with a bit-exact
// integer square root and CORDIC vectoring model. Every sphere transaction is
// checked in order against the oldest prediction. Directed corner points come
// first, then random points with idling on both sides, a long output hold-off
// that fills the pipeline, and a stream with no idling at all.
// ----------------------------------------------------------------------------
module tb_top;
	import c2s_pkg::*;

	localparam int COORD_WIDTH   = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int PIPE_LATENCY  = 39 + CORDIC_STAGES;
	localparam int DRAIN_CYCLES  = 3 * PIPE_LATENCY;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int IDLE_PCT      = 12;
	localparam int REPORT_MAX    = 10;

	// fixed point of the angle model
	localparam int    FRAC_BITS    = 32 - COORD_WIDTH;
	localparam longint COORD_SCALE = 64'sd1 << (FRAC_BITS + 8);
	localparam longint GUARD_SCALE = 64'sd1 << 8;
	localparam longint QUARTER_TURN = 64'sd1073741824;
	localparam longint ROUND_HALF  = 64'sd32768;
	localparam longint THETA_MAX   = 64'sd32768;
	localparam longint unsigned RADIUS_SAT = 64'd65535;

	// atan(2^-i), 2^32 per full turn
	localparam longint ATAN_LUT [24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
		64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
		64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
		64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	c2s_point_if #(.COORD_WIDTH(COORD_WIDTH)) point_ch();
	c2s_sphere_if sphere_ch();

	cartesian_to_spherical_core #(
		.COORD_WIDTH(COORD_WIDTH),
		.CORDIC_STAGES(CORDIC_STAGES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.point(point_ch),
		.sphere(sphere_ch)
	);

	sph_t pending_spheres [$];
	int   mismatch_count = 0;
	int   cycle_count = 0;
	int   hold_cycles = 0;
	bit   idle_on = 1'b1;

	always #5 clk = ~clk;

	// integer square root, floor
	function automatic longint unsigned floor_sqrt(longint unsigned s);
		longint unsigned root, probe;
		root = 0;
		probe = 64'd1 << 62;
		while (probe > s)
			probe = probe >> 2;
		while (probe != 0) begin
			if (s >= root + probe) begin
				s = s - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	// vectoring rotations toward the +a axis, returns the swept angle
	function automatic longint vector_sweep(longint a, longint b);
		longint acc, da, db;
		acc = 0;
		for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			da = b >>> i;
			db = a >>> i;
			if (b >= 0) begin
				a = a + da;
				b = b - db;
				acc = acc + ATAN_LUT[i];
			end else begin
				a = a - da;
				b = b + db;
				acc = acc - ATAN_LUT[i];
			end
		end
		return acc;
	endfunction

	// expected spherical coordinates of one point
	function automatic sph_t to_spherical(logic signed [COORD_WIDTH-1:0] xi,
		logic signed [COORD_WIDTH-1:0] yi, logic signed [COORD_WIDTH-1:0] zi);
		sph_t res;
		longint x, y, z, rho, a, b, swap, acc, t, p;
		longint unsigned ax, ay, az, rho_sq, norm_sq, r;
		x = xi;
		y = yi;
		z = zi;
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		az = (z < 0) ? -z : z;
		rho_sq = ax * ax + ay * ay;
		norm_sq = rho_sq + az * az;

		// radius rounded to nearest, saturated
		r = floor_sqrt(norm_sq);
		if (norm_sq - r * r > r)
			r = r + 1;
		if (r > RADIUS_SAT)
			r = RADIUS_SAT;
		res.radius = r[15:0];
		res.undefined = (x == 0 && y == 0);

		if (res.undefined) begin
			res.polar_angle = (z < 0) ? ANG_PI : ANG_ZERO;
			res.azimuth = ANG_ZERO;
		end else begin
			// theta from (z, rho)
			if (z == 0) begin
				res.polar_angle = ANG_HALF_PI;
			end else begin
				rho = longint'(floor_sqrt(rho_sq << (2 * FRAC_BITS)));
				a = z * COORD_SCALE;
				b = rho * GUARD_SCALE;
				acc = 0;
				if (a < 0) begin
					swap = b;
					b = -a;
					a = swap;
					acc = QUARTER_TURN;
				end
				acc = acc + vector_sweep(a, b);
				t = (acc + ROUND_HALF) >>> 16;
				if (t < 0)
					t = 0;
				if (t > THETA_MAX)
					t = THETA_MAX;
				res.polar_angle = t[15:0];
			end

			// phi from (x, y)
			if (x == 0) begin
				res.azimuth = (y > 0) ? ANG_HALF_PI : ANG_NEG_HALF_PI;
			end else if (y == 0) begin
				res.azimuth = (x > 0) ? ANG_ZERO : ANG_PI;
			end else begin
				a = x * COORD_SCALE;
				b = y * COORD_SCALE;
				acc = 0;
				if (a < 0) begin
					if (b >= 0) begin
						swap = b;
						b = -a;
						a = swap;
						acc = QUARTER_TURN;
					end else begin
						swap = -b;
						b = a;
						a = swap;
						acc = -QUARTER_TURN;
					end
				end
				acc = acc + vector_sweep(a, b);
				p = (acc + ROUND_HALF) >>> 16;
				res.azimuth = p[15:0];
			end
		end
		return res;
	endfunction

	// compare one sphere transaction with the oldest prediction
	task automatic check_sphere();
		sph_t got, want;
		got.radius = sphere_ch.radius;
		got.polar_angle = sphere_ch.polar_angle;
		got.azimuth = sphere_ch.azimuth;
		got.undefined = sphere_ch.undefined;
		if (pending_spheres.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("unexpected transaction: r=%0d theta=%0d phi=%0d undef=%0b",
					got.radius, got.polar_angle, got.azimuth, got.undefined);
			return;
		end
		want = pending_spheres.pop_front();
		if (got.radius !== want.radius || got.polar_angle !== want.polar_angle ||
			got.azimuth !== want.azimuth || got.undefined !== want.undefined) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX) begin
				$display("mismatch: exp r=%0d theta=%0d phi=%0d undef=%0b",
					want.radius, want.polar_angle, want.azimuth, want.undefined);
				$display("          got r=%0d theta=%0d phi=%0d undef=%0b",
					got.radius, got.polar_angle, got.azimuth, got.undefined);
			end
		end
	endtask

	// sphere receiver: checks transactions, idles and holds off on request
	initial begin
		bit take;
		sphere_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && sphere_ch.valid && sphere_ch.ready)
				check_sphere();
			if (hold_cycles > 0) begin
				hold_cycles--;
				take = 1'b0;
			end else begin
				take = !(idle_on && $urandom_range(99) < IDLE_PCT);
			end
			sphere_ch.ready <= take && arst_n;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// offer one point, return once it is accepted
	task automatic send_point(logic signed [COORD_WIDTH-1:0] x,
		logic signed [COORD_WIDTH-1:0] y, logic signed [COORD_WIDTH-1:0] z);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			point_ch.valid <= 1'b0;
			@(posedge clk);
		end
		point_ch.valid <= 1'b1;
		point_ch.x_coord <= x;
		point_ch.y_coord <= y;
		point_ch.z_coord <= z;
		do
			@(posedge clk);
		while (!point_ch.ready);
		pending_spheres.push_back(to_spherical(x, y, z));
	endtask

	// one random coordinate, biased toward zeros, extremes and small values
	function automatic logic signed [COORD_WIDTH-1:0] pick_coord(int kind);
		int corners [6] = '{-32768, -32767, -1, 0, 1, 32767};
		case (kind)
			0, 1, 2, 3, 4: return COORD_WIDTH'($urandom);
			5: return COORD_WIDTH'(int'($urandom_range(128)) - 64);
			6: return ($urandom_range(2) == 0) ? '0 : COORD_WIDTH'($urandom);
			7: return ($urandom_range(1) == 0) ? '0 :
				COORD_WIDTH'(int'($urandom_range(6)) - 3);
			default: return COORD_WIDTH'(corners[$urandom_range(5)]);
		endcase
	endfunction

	task automatic send_random_points(int count);
		int kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(8);
			send_point(pick_coord(kind), pick_coord(kind), pick_coord(kind));
		end
	endtask

	// axes, origin, z plane and extremes
	task automatic test_corner_points();
		int pts [22][3] = '{
			'{0, 0, 0}, '{0, 0, 100}, '{0, 0, -100}, '{0, 0, 32767},
			'{0, 0, -32768}, '{1, 0, 0}, '{-1, 0, 0}, '{0, 1, 0},
			'{0, -1, 0}, '{32767, 0, 5}, '{-32768, 0, -5}, '{0, 32767, 0},
			'{0, -32768, 7}, '{100, 200, 0}, '{-32768, -32768, 0},
			'{32767, 32767, 32767}, '{-32768, -32768, -32768},
			'{32767, -32768, -32768}, '{-32768, 32767, 1}, '{1, 1, -32768},
			'{-1, -1, 32767}, '{1000, -1000, 1}
		};
		for (int i = 0; i < 22; i++)
			send_point(COORD_WIDTH'(pts[i][0]), COORD_WIDTH'(pts[i][1]),
				COORD_WIDTH'(pts[i][2]));
	endtask

	task automatic test_random_points();
		send_random_points(1400);
	endtask

	// output held off long enough to fill the pipeline and stall the input
	task automatic test_output_hold_off();
		hold_cycles = 8 * PIPE_LATENCY;
		send_random_points(150);
	endtask

	// back-to-back stream with no idling on either side
	task automatic test_full_rate_stream();
		idle_on = 1'b0;
		send_random_points(280);
		idle_on = 1'b1;
	endtask

	initial begin
		point_ch.valid = 1'b0;
		point_ch.x_coord = '0;
		point_ch.y_coord = '0;
		point_ch.z_coord = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_points();
		test_random_points();
		test_output_hold_off();
		test_full_rate_stream();
		point_ch.valid <= 1'b0;

		// drain the pipeline, then watch for stray transactions
		while (pending_spheres.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
